### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define WMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define WMF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hdl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// shared widths, register indexes, mode codes and control types of the
// window median / trimmed mean filter
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int MODE_W         = 2;
  localparam int WLEN_W         = 5;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 8;
  localparam int MAX_WINDOW_DEF = 16;
  localparam int MIN_WINDOW     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 4'd1;

  // filter modes, any other code acts as median
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIM   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_MEDIAN;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd5;

  typedef struct packed {
    logic load_sample;
    logic insert;
    logic acc_step;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic window_done;
    logic acc_last;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

### hdl/wmf_ctrl.sv
// ----------------------------------------------------------------------------
// wmf_ctrl
// sequencer: sample capture, sorted insert, window accumulate, divide and
// output register handoff
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire wmf_pkg::sts_t st,
  output wmf_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INSERT = 5'b00010,
    S_ACC    = 5'b00100,
    S_DIV    = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = st.window_done ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        if (st.acc_last) begin
          cmd.div_load = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // wait until the output register is free or being emptied
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

### hdl/wmf_dp.sv
// ----------------------------------------------------------------------------
// wmf_dp
// datapath: sorted window store with parallel insert, accumulator over a
// range of sorted entries, restoring divider and output data register
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_dp #(
  parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wmf_pkg::cmd_t                 cmd,
  output wmf_pkg::sts_t                      st,
  input  wire logic [wmf_pkg::MODE_W-1:0]    mode,
  input  wire logic [wmf_pkg::WLEN_W-1:0]    wlen,
  input  wire logic [wmf_pkg::SAMPLE_W-1:0]  sample,
  output logic      [wmf_pkg::SAMPLE_W-1:0]  filtered
);

  localparam int SW    = wmf_pkg::SAMPLE_W;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CMP_W = (LEN_W > wmf_pkg::WLEN_W) ? LEN_W : wmf_pkg::WLEN_W;
  localparam int SUM_W = SW + LEN_W;
  localparam int DC_W  = $clog2(SUM_W + 1);

  logic [SW-1:0]    smp;
  logic [SW-1:0]    store      [MAX_WINDOW];
  logic [SW-1:0]    store_next [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] gt;
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] eff_len;
  logic [CMP_W-1:0] wl_ext;

  logic [IDX_W-1:0] k;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] dvsr;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] sum_next;
  logic [SW-1:0]    rd_data;

  logic [LEN_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [DC_W-1:0]  dcnt;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             q_bit;

  logic [IDX_W-1:0] first_idx;
  logic [LEN_W-1:0] take_cnt;

  logic [SW-1:0]    out_data;

  // clamp the programmed length into the legal window range
  assign wl_ext = CMP_W'(wlen);
  always_comb begin
    if (wl_ext < CMP_W'(wmf_pkg::MIN_WINDOW)) begin
      eff_len = LEN_W'(wmf_pkg::MIN_WINDOW);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wl_ext);
    end
  end

  assign st.window_done = ({1'b0, fill} + (LEN_W+1)'(1)) >= {1'b0, eff_len};

  // each slot keeps its entry, takes its lower neighbor, or takes the sample
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      gt[i] = (i < int'(fill)) && (store[i] > smp);
    end
    store_next[0] = ((fill != '0) && !gt[0]) ? store[0] : smp;
    for (int i = 1; i < MAX_WINDOW; i++) begin
      if ((i < int'(fill)) && !gt[i]) begin
        store_next[i] = store[i];
      end else if (gt[i-1]) begin
        store_next[i] = store[i-1];
      end else if (i <= int'(fill)) begin
        store_next[i] = smp;
      end else begin
        store_next[i] = store[i];
      end
    end
  end

  // entry range and divisor per mode
  always_comb begin
    case (mode)
      wmf_pkg::MODE_MEAN: begin
        first_idx = '0;
        take_cnt  = eff_len;
      end
      wmf_pkg::MODE_TRIM: begin
        first_idx = IDX_W'(1);
        take_cnt  = eff_len - LEN_W'(2);
      end
      default: begin
        first_idx = IDX_W'(eff_len >> 1);
        take_cnt  = LEN_W'(1);
      end
    endcase
  end

  assign rd_data     = store[k];
  assign sum_next    = acc + SUM_W'(rd_data);
  assign st.acc_last = (cnt == LEN_W'(1));

  // restoring divide, one quotient bit a cycle
  assign shifted     = {rem, quo[SUM_W-1]};
  assign diff        = shifted - {1'b0, dvsr};
  assign q_bit       = (shifted >= {1'b0, dvsr});
  assign st.div_last = (dcnt == DC_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      smp <= sample;
    end
    if (cmd.insert) begin
      store <= store_next;
    end
    if (cmd.insert && st.window_done) begin
      k    <= first_idx;
      dvsr <= take_cnt;
      acc  <= '0;
    end else if (cmd.acc_step) begin
      k   <= k + IDX_W'(1);
      acc <= sum_next;
    end
    if (cmd.div_load) begin
      quo <= sum_next;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], q_bit};
      rem <= q_bit ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
    if (cmd.load_out) begin
      out_data <= quo[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cnt  <= '0;
      dcnt <= '0;
    end else begin
      if (cmd.insert) begin
        fill <= st.window_done ? '0 : fill + LEN_W'(1);
      end
      if (cmd.insert && st.window_done) begin
        cnt <= take_cnt;
      end else if (cmd.acc_step) begin
        cnt <= cnt - LEN_W'(1);
      end
      if (cmd.div_load) begin
        dcnt <= DC_W'(SUM_W);
      end else if (cmd.div_step) begin
        dcnt <= dcnt - DC_W'(1);
      end
    end
  end

  assign filtered = out_data;

endmodule

`default_nettype wire

### hdl/window_median_trimmed_mean_filter_core.sv
// a sample that does not complete a window passes through insert and back to ready
// a completing sample passes insert, a serial sum of n entries, a divide and the
// output handoff; n is the window length, length-2, or 1 for median
// the accumulator is serial and the divider makes one quotient bit per cycle
// the output register holds a result while the next sample is taken
// synchronous reset clears the fill count and handshakes, mode to median, length 5
// ----------------------------------------------------------------------------
// window_median_trimmed_mean_filter_core
// windowed mean, median or trimmed mean over sorted converter samples
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module window_median_trimmed_mean_filter_core #(
  parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [wmf_pkg::SAMPLE_W-1:0]    sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [wmf_pkg::SAMPLE_W-1:0]    filtered,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [wmf_pkg::MODE_W-1:0] filter_mode;
  logic [wmf_pkg::WLEN_W-1:0] window_len;
  wmf_pkg::cmd_t              cmd;
  wmf_pkg::sts_t              st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= wmf_pkg::MODE_RESET;
      window_len  <= wmf_pkg::WLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmf_pkg::REG_FILTER_MODE: filter_mode <= cfg_data[wmf_pkg::MODE_W-1:0];
        wmf_pkg::REG_WINDOW_LEN:  window_len  <= cfg_data[wmf_pkg::WLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  wmf_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .mode     (filter_mode),
    .wlen     (window_len),
    .sample   (sample),
    .filtered (filtered)
  );

  `WMF_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after accept")
  `WMF_ASSERT(a_hold_after_divide, cmd.div_step && st.div_last |=> !in_ready, "ready before output")
  `WMF_ASSERT(a_load_sets_valid, cmd.load_out |=> out_valid, "result not presented")
  `WMF_ASSERT_NEVER(a_idle_while_busy, in_ready && (cmd.acc_step || cmd.div_step), "ready mid window")

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the window filter core: samples go in over a valid/ready channel,
// a scoreboard keeps its own sorted window and mode/length registers and
// predicts each filtered value, compared in order as results are taken out
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmf_pkg::*;

  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_PCT       = 13;
  localparam int SETTLE_CYCLES  = 48;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 927;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int CFG_IDX_MAX    = (1 << CFG_IDX_W) - 1;
  // unused mode code, acts as median
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  class filter_scoreboard;
    logic [SAMPLE_W-1:0] sorted_window [MAX_WINDOW_DEF];
    int unsigned         fill;
    logic [MODE_W-1:0]   mode;
    logic [WLEN_W-1:0]   wlen;
    logic [SAMPLE_W-1:0] expected_filtered [$];
    int unsigned         n_errors;
    int unsigned         n_samples;
    int unsigned         n_results;
    int unsigned         n_writes;

    function new();
      foreach (sorted_window[i]) sorted_window[i] = '0;
      fill = 0;
      mode = MODE_RESET;
      wlen = WLEN_RESET;
      n_errors = 0;
      n_samples = 0;
      n_results = 0;
      n_writes = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      if (idx == REG_FILTER_MODE) mode = data[MODE_W-1:0];
      else if (idx == REG_WINDOW_LEN) wlen = data[WLEN_W-1:0];
    endfunction

    function logic [SAMPLE_W-1:0] window_mean(int unsigned first, int unsigned count);
      int unsigned sum;
      sum = 0;
      for (int unsigned i = 0; i < count; i++) begin
        if (first + i < MAX_WINDOW_DEF) sum += sorted_window[first + i];
      end
      return SAMPLE_W'(sum / count);
    endfunction

    // insert one sample in order; a completed window queues its filtered value
    function void take_sample(logic [SAMPLE_W-1:0] s);
      int unsigned pos;
      int unsigned len;
      logic [SAMPLE_W-1:0] res;
      n_samples++;
      pos = (fill >= MAX_WINDOW_DEF) ? MAX_WINDOW_DEF - 1 : fill;
      while (pos > 0 && sorted_window[pos-1] > s) begin
        sorted_window[pos] = sorted_window[pos-1];
        pos--;
      end
      sorted_window[pos] = s;
      if (fill < MAX_WINDOW_DEF) fill++;
      len = wlen;
      if (len < MIN_WINDOW) len = MIN_WINDOW;
      if (len > MAX_WINDOW_DEF) len = MAX_WINDOW_DEF;
      if (fill < len) return;
      case (mode)
        MODE_MEAN: res = window_mean(0, len);
        MODE_TRIM: res = window_mean(1, len - 2);
        default:   res = sorted_window[len / 2];
      endcase
      fill = 0;
      expected_filtered.push_back(res);
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_filtered(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_filtered.size() == 0) begin
        report_mismatch($sformatf("filtered %0d with no window completed", got));
        return;
      end
      want = expected_filtered.pop_front();
      n_results++;
      if (got !== want)
        report_mismatch($sformatf("filtered got %0d want %0d (result %0d)",
                                  got, want, n_results));
    endtask

    function int pending();
      return expected_filtered.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   filtered;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  filter_scoreboard sb = new();
  bit               steady = 1'b0;
  int unsigned      quiet_cycles = 0;

  window_median_trimmed_mean_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // valid stays high across back-to-back transactions, lowered only for a gap
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_sample(s);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // block idle: every result out, plus time for a non-completing insert
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_filtered(filtered);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned         random_sent;
    int unsigned         phase;
    int unsigned         n_items;
    int unsigned         pick;
    logic [SAMPLE_W-1:0] s;
    logic [MODE_W-1:0]   m;
    logic [WLEN_W-1:0]   l;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: median of 5, extremes and alternating bit patterns
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h800);
    settle();

    // shortest window, mean at full scale
    cfg_write(REG_FILTER_MODE, CFG_DATA_W'(MODE_MEAN));
    cfg_write(REG_WINDOW_LEN, CFG_DATA_W'(MIN_WINDOW));
    cfg_valid <= 1'b0;
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    settle();

    // trimmed mean drops both extremes
    cfg_write(REG_FILTER_MODE, CFG_DATA_W'(MODE_TRIM));
    cfg_valid <= 1'b0;
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'h007);
    settle();

    // even length median takes the upper middle
    cfg_write(REG_FILTER_MODE, CFG_DATA_W'(MODE_MEDIAN));
    cfg_write(REG_WINDOW_LEN, 8'd4);
    cfg_valid <= 1'b0;
    send_sample(12'd10);
    send_sample(12'd40);
    send_sample(12'd20);
    send_sample(12'd30);
    settle();

    // write past the register list, spare mode code, length below the minimum
    cfg_write(CFG_IDX_W'(CFG_IDX_MAX), 8'hFF);
    cfg_write(REG_FILTER_MODE, 8'hFF);
    cfg_write(REG_WINDOW_LEN, 8'h00);
    cfg_valid <= 1'b0;
    send_sample(12'd5);
    send_sample(12'd1);
    send_sample(12'd3);
    settle();

    // length cut below the fill count while a window is open
    cfg_write(REG_FILTER_MODE, CFG_DATA_W'(MODE_MEAN));
    cfg_write(REG_WINDOW_LEN, 8'd5);
    cfg_valid <= 1'b0;
    send_sample(12'd100);
    send_sample(12'd1);
    send_sample(12'd2);
    send_sample(12'd3);
    settle();
    cfg_write(REG_WINDOW_LEN, CFG_DATA_W'(MIN_WINDOW));
    cfg_valid <= 1'b0;
    send_sample(12'hFFF);

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(9) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(CFG_IDX_MAX, int'(REG_WINDOW_LEN) + 1)),
                  CFG_DATA_W'($urandom));
      if (phase == 0 || $urandom_range(3) != 0) begin
        m = ($urandom_range(7) == 0) ? MODE_SPARE : MODE_W'($urandom_range(MODE_TRIM));
        cfg_write(REG_FILTER_MODE, {(CFG_DATA_W - MODE_W)'($urandom), m});
      end
      if (phase == 0 || $urandom_range(3) != 0) begin
        if ($urandom_range(6) == 0) begin
          cfg_write(REG_WINDOW_LEN, CFG_DATA_W'($urandom));
        end else begin
          l = ($urandom_range(9) < 6) ? WLEN_W'($urandom_range(6, MIN_WINDOW))
                                      : WLEN_W'($urandom_range(MAX_WINDOW_DEF, MIN_WINDOW));
          cfg_write(REG_WINDOW_LEN, {(CFG_DATA_W - WLEN_W)'($urandom), l});
        end
      end
      cfg_valid <= 1'b0;
      // a few phases run with neither side ever holding off
      steady = (phase >= 4 && phase < 7);
      n_items = $urandom_range(110, 20);
      repeat (n_items) begin
        pick = $urandom_range(9);
        if (pick < 7) s = SAMPLE_W'($urandom);
        else if (pick == 7) s = $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
        else if (pick == 8) s = SAMPLE_W'($urandom_range(3));
        else s = SAMPLE_W'($urandom_range(SAMPLE_MAX, SAMPLE_MAX - 3));
        send_sample(s);
        random_sent++;
      end
      phase++;
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples over %0d setting phases, %0d register writes",
             sb.n_samples, phase + 6, sb.n_writes);
    $display("%0d filtered results checked, %0d mismatches", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
